// File: rtl/ehu_pkg.sv
// Shared types, constants and hex helpers for the equals-hex unescape block.
// No dependencies; imported by every module of the block.
package ehu_pkg;

  localparam logic [7:0] EQ_CHAR = 8'h3D;
  localparam int unsigned MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_EQ       = 2'd1,
    PH_EQ_DIGIT = 2'd2,
    PH_DROP     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eos;
  } result_t;

  typedef result_t [MAX_RESULTS-1:0] result_set_t;

  function automatic logic hex_valid(input logic [7:0] c);
    hex_valid = (c >= 8'h30 && c <= 8'h39) ||
                (c >= 8'h61 && c <= 8'h66) ||
                (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Map an ASCII hex digit to its nibble; non-digits give zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    hex_value = v[3:0];
  endfunction

endpackage

// File: rtl/ehu_decode.sv
// Combinational next-state and result logic for one input byte.
// Depends on ehu_pkg.
module ehu_decode (
  input  ehu_pkg::phase_t     phase,
  input  logic [7:0]          held,
  input  logic [7:0]          in_byte,
  input  logic                last,
  output ehu_pkg::result_set_t res,
  output logic [1:0]          res_cnt,
  output ehu_pkg::phase_t     phase_next,
  output logic [7:0]          held_next
);
  import ehu_pkg::*;

  always_comb begin
    logic [1:0] n;
    n          = 2'd0;
    res        = '0;
    phase_next = phase;
    held_next  = held;

    case (phase)
      PH_DROP: begin
        phase_next = PH_DROP;
      end
      default: begin
        if (in_byte == 8'h00) begin
          // flush any pending escape literally, then drop the rest
          if (phase == PH_EQ || phase == PH_EQ_DIGIT) begin
            res[n] = '{data: EQ_CHAR, present: 1'b1, eos: 1'b0};
            n = n + 2'd1;
          end
          if (phase == PH_EQ_DIGIT) begin
            res[n] = '{data: held, present: 1'b1, eos: 1'b0};
            n = n + 2'd1;
          end
          phase_next = PH_DROP;
        end else if (phase == PH_IDLE) begin
          if (in_byte == EQ_CHAR) begin
            phase_next = PH_EQ;
          end else begin
            res[n] = '{data: in_byte, present: 1'b1, eos: 1'b0};
            n = n + 2'd1;
          end
        end else if (phase == PH_EQ) begin
          if (hex_valid(in_byte)) begin
            held_next  = in_byte;
            phase_next = PH_EQ_DIGIT;
          end else begin
            res[n] = '{data: EQ_CHAR, present: 1'b1, eos: 1'b0};
            n = n + 2'd1;
            if (in_byte == EQ_CHAR) begin
              phase_next = PH_EQ;
            end else begin
              res[n] = '{data: in_byte, present: 1'b1, eos: 1'b0};
              n = n + 2'd1;
              phase_next = PH_IDLE;
            end
          end
        end else begin
          if (hex_valid(in_byte)) begin
            res[n] = '{data: {hex_value(held), hex_value(in_byte)}, present: 1'b1,
                       eos: 1'b0};
            n = n + 2'd1;
            phase_next = PH_IDLE;
          end else begin
            res[n] = '{data: EQ_CHAR, present: 1'b1, eos: 1'b0};
            n = n + 2'd1;
            res[n] = '{data: held, present: 1'b1, eos: 1'b0};
            n = n + 2'd1;
            if (in_byte == EQ_CHAR) begin
              phase_next = PH_EQ;
            end else begin
              res[n] = '{data: in_byte, present: 1'b1, eos: 1'b0};
              n = n + 2'd1;
              phase_next = PH_IDLE;
            end
          end
        end
      end
    endcase

    if (last) begin
      if (phase_next == PH_EQ || phase_next == PH_EQ_DIGIT) begin
        res[n] = '{data: EQ_CHAR, present: 1'b1, eos: 1'b0};
        n = n + 2'd1;
      end
      if (phase_next == PH_EQ_DIGIT) begin
        res[n] = '{data: held_next, present: 1'b1, eos: 1'b0};
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        res[0] = '{data: 8'h00, present: 1'b0, eos: 1'b0};
        n = 2'd1;
      end
      res[n - 2'd1].eos = 1'b1;
      phase_next = PH_IDLE;
      held_next  = 8'h00;
    end

    res_cnt = n;
  end

endmodule

// File: rtl/ehu_out_queue.sv
// Holds up to three results of one byte; drained one per cycle on out_ready.
// Depends on ehu_pkg.
module ehu_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ehu_pkg::result_set_t load_res,
  input  logic [1:0]           load_cnt,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ehu_pkg::result_t     out_res
);
  import ehu_pkg::*;

  result_set_t slots;
  logic [1:0]  cnt;
  logic [1:0]  rd;
  logic        pop;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign out_res   = slots[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd  <= 2'd0;
    end else if (load) begin
      cnt <= load_cnt;
      rd  <= 2'd0;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
      rd  <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_res;
    end
  end

endmodule

// File: rtl/equals_hex_unescape.sv
// Top level of the equals-hex unescape stream decoder: '=' plus two hex digits
// becomes one byte, other bytes pass through, a zero byte ends the string.
// An accepted request shows its first result on the output in the next cycle.
// One input byte is taken per cycle while each byte yields at most one
// result and m_tready is high; a byte that yields two or three results
// holds the input until its last result leaves the three-entry register.
// Reset (rst, synchronous, active high): idle phase, no held digit, no results.
module equals_hex_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] byte_present
  output logic       m_tlast    // end_of_string
);
  import ehu_pkg::*;

  phase_t      phase;
  logic [7:0]  held;
  phase_t      phase_next;
  logic [7:0]  held_next;
  result_set_t dec_res;
  logic [1:0]  dec_cnt;
  logic        accept;
  result_t     out_res;

  // Decode straight from the input request against the current phase.
  ehu_decode u_decode (
    .phase      (phase),
    .held       (held),
    .in_byte    (s_tdata),
    .last       (s_tlast),
    .res        (dec_res),
    .res_cnt    (dec_cnt),
    .phase_next (phase_next),
    .held_next  (held_next)
  );

  // Accept only when the result register is empty or drains this cycle.
  assign accept = s_tvalid && s_tready;

  ehu_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_res  (dec_res),
    .load_cnt  (dec_cnt),
    .can_load  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tuser = out_res.present;
  assign m_tlast = out_res.eos;

  // Advance the escape phase and held digit on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  // A request taken while dropping produces nothing unless it ends the string.
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DROP && !s_tlast |-> dec_cnt == 2'd0)
    else $error("output produced while dropping after a zero byte");

  // The end flag always returns the decoder to a clean idle state.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> phase == PH_IDLE && held == 8'h00)
    else $error("decoder not idle after end of string");

  // A flagged request always yields a result, shown in the next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> m_tvalid)
    else $error("end of string produced no result");

  // While waiting for the second hex digit, the held digit is a valid hex digit.
  a_held_digit: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EQ_DIGIT |-> hex_valid(held))
    else $error("held digit is not a hex digit");

endmodule
